// ----- rtl/lsb_pixel_bit_embed_extract_defines.svh -----
// ----------------------------------------------------------------------------
// LSB embed/extract assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LSB_PIXEL_BIT_EMBED_EXTRACT_DEFINES_SVH
`define LSB_PIXEL_BIT_EMBED_EXTRACT_DEFINES_SVH

// condition holds at every edge out of reset
`define LSBE_ASSERT_HOLDS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define LSBE_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSBE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lsbe_pkg.sv -----
// ----------------------------------------------------------------------------
// LSB embed/extract package
// Request codes, register indexes, field widths and the result beat type.
// ----------------------------------------------------------------------------
package lsbe_pkg;

    localparam int CFG_W  = 13;
    localparam int POS_W  = 12;
    localparam int BYTE_W = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [1:0] {
        REQ_EMBED   = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_REWIND  = 2'd2,
        REQ_NOP     = 2'd3
    } req_type_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    localparam logic [1:0] CH_RED  = 2'd0;
    localparam logic [1:0] CH_BLUE = 2'd2;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic              is_write;
        logic [POS_W-1:0]  pixel_x;
        logic [POS_W-1:0]  pixel_y;
        logic [1:0]        channel;
        logic              bit_value;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_out;
        logic              exhausted;
        logic              last;
    } result_t;

endpackage

// ----- rtl/lsbe_if.sv -----
// ----------------------------------------------------------------------------
// LSB embed/extract channels
// Request and result valid/ready channels with their payload fields.
// ----------------------------------------------------------------------------
interface lsbe_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] message_byte;
    logic [7:0] channel_sample;

    modport source (output valid, output req_type, output message_byte,
                    output channel_sample, input ready);
    modport sink   (input valid, input req_type, input message_byte,
                    input channel_sample, output ready);
endinterface

interface lsbe_res_if;
    logic        valid;
    logic        ready;
    logic        is_write;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [1:0]  channel;
    logic        bit_value;
    logic        byte_valid;
    logic [7:0]  byte_out;
    logic        exhausted;
    logic        last;

    modport source (output valid, output is_write, output pixel_x, output pixel_y,
                    output channel, output bit_value, output byte_valid,
                    output byte_out, output exhausted, output last, input ready);
    modport sink   (input valid, input is_write, input pixel_x, input pixel_y,
                    input channel, input bit_value, input byte_valid,
                    input byte_out, input exhausted, input last, output ready);
endinterface

// ----- rtl/lsbe_apb_regs.sv -----
// ----------------------------------------------------------------------------
// LSB embed/extract register file
// APB image size registers with clamped dimensions for the raster walk.
// ----------------------------------------------------------------------------
module lsbe_apb_regs #(
    parameter int MAX_DIM = 4096,
    localparam int CW     = $clog2(MAX_DIM),
    localparam int CMPW   = (CW + 1 > lsbe_pkg::CFG_W) ? CW + 1 : lsbe_pkg::CFG_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsbe_pkg::APB_AW-1:0]  paddr,
    input  logic [lsbe_pkg::APB_DW-1:0]  pwdata,
    output logic [lsbe_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output logic [CMPW-1:0]              dim_w,
    output logic [CMPW-1:0]              dim_h
);

    localparam logic [CMPW-1:0] DIM_MAX = CMPW'(MAX_DIM);
    localparam logic [CMPW-1:0] DIM_MIN = CMPW'(1);

    logic [lsbe_pkg::CFG_W-1:0] width_reg;
    logic [lsbe_pkg::CFG_W-1:0] height_reg;
    lsbe_pkg::reg_index_t       reg_sel;
    logic                       wr_en;
    logic [CMPW-1:0]            w_ext;
    logic [CMPW-1:0]            h_ext;

    assign pready  = 1'b1;
    assign reg_sel = lsbe_pkg::reg_index_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lsbe_pkg::WIDTH_RESET;
            height_reg <= lsbe_pkg::HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                lsbe_pkg::REG_IMAGE_WIDTH:  width_reg  <= pwdata[lsbe_pkg::CFG_W-1:0];
                lsbe_pkg::REG_IMAGE_HEIGHT: height_reg <= pwdata[lsbe_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            lsbe_pkg::REG_IMAGE_WIDTH:
                prdata = lsbe_pkg::APB_DW'(width_reg);
            lsbe_pkg::REG_IMAGE_HEIGHT:
                prdata = lsbe_pkg::APB_DW'(height_reg);
            default:
                prdata = '0;
        endcase
    end

    assign w_ext = CMPW'(width_reg);
    assign h_ext = CMPW'(height_reg);

    // zero acts as one, oversize acts as MAX_DIM
    always_comb
    begin
        priority if (w_ext == '0)
            dim_w = DIM_MIN;
        else if (w_ext > DIM_MAX)
            dim_w = DIM_MAX;
        else
            dim_w = w_ext;

        priority if (h_ext == '0)
            dim_h = DIM_MIN;
        else if (h_ext > DIM_MAX)
            dim_h = DIM_MAX;
        else
            dim_h = h_ext;
    end

endmodule

// ----- rtl/lsbe_engine.sv -----
// ----------------------------------------------------------------------------
// LSB embed/extract engine
// Request slot, raster cursor state and the one-result-per-cycle step logic, held while the output is full.
// ----------------------------------------------------------------------------
`include "lsb_pixel_bit_embed_extract_defines.svh"

module lsbe_engine #(
    parameter int MAX_DIM = 4096,
    localparam int CW     = $clog2(MAX_DIM),
    localparam int CMPW   = (CW + 1 > lsbe_pkg::CFG_W) ? CW + 1 : lsbe_pkg::CFG_W
) (
    input  logic              clk,
    input  logic              rst_n,
    lsbe_req_if.sink          req,
    input  logic [CMPW-1:0]   dim_w,
    input  logic [CMPW-1:0]   dim_h,
    input  logic              out_space,
    output logic              out_load,
    output lsbe_pkg::result_t out_data
);

    typedef logic [lsbe_pkg::POS_W-1:0] pos_t;

    // request slot
    logic                   slot_v_reg,   slot_v_next;
    lsbe_pkg::req_type_t    slot_req_reg;
    logic [7:0]             slot_msg_reg;
    logic [7:0]             slot_smp_reg;
    logic [2:0]             idx_reg;

    // cursor state
    logic [CW-1:0]          cx_reg,   cx_next;
    logic [CW-1:0]          cy_reg,   cy_next;
    logic [1:0]             ch_reg,   ch_next;
    logic [7:0]             asm_reg,  asm_next;
    logic [2:0]             cnt_reg,  cnt_next;
    logic                   done_reg, done_next;

    logic                   fire;
    logic                   accept;
    logic                   item_end;
    lsbe_pkg::req_type_t    in_req;

    logic [CW-1:0]          adv_cx;
    logic [CW-1:0]          adv_cy;
    logic [1:0]             adv_ch;
    logic                   adv_done;
    logic                   x_more;
    logic                   y_more;
    logic [7:0]             asm_sum;
    lsbe_pkg::result_t      res;

    logic                   embed_fire;
    logic                   rewind_fire;
    logic                   idx_last;
    logic                   state_clear;

    assign in_req   = lsbe_pkg::req_type_t'(req.req_type);
    assign fire     = slot_v_reg && out_space;
    assign item_end = fire && res.last;
    assign req.ready = !slot_v_reg || item_end;
    assign accept   = req.valid && req.ready;
    assign out_load = fire;
    assign out_data = res;

    always_comb
    begin
        slot_v_next = slot_v_reg;
        if (accept && (in_req != lsbe_pkg::REQ_NOP))
            slot_v_next = 1'b1;
        else if (item_end)
            slot_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_v_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            slot_v_reg <= slot_v_next;
            if (accept)
                idx_reg <= '0;
            else if (fire)
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_req_reg <= in_req;
            slot_msg_reg <= req.message_byte;
            slot_smp_reg <= req.channel_sample;
        end
    end

    // raster advance by one channel
    assign x_more = (CMPW'(cx_reg) + CMPW'(1)) < dim_w;
    assign y_more = (CMPW'(cy_reg) + CMPW'(1)) < dim_h;

    always_comb
    begin
        adv_cx   = cx_reg;
        adv_cy   = cy_reg;
        adv_ch   = ch_reg + 2'd1;
        adv_done = done_reg;
        if (ch_reg == lsbe_pkg::CH_BLUE)
        begin
            adv_ch = lsbe_pkg::CH_RED;
            priority if (x_more)
                adv_cx = cx_reg + CW'(1);
            else if (y_more)
            begin
                adv_cx = '0;
                adv_cy = cy_reg + CW'(1);
            end
            else
                adv_done = 1'b1;
        end
    end

    assign asm_sum = asm_reg | (8'(slot_smp_reg[0]) << cnt_reg);

    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        ch_next   = ch_reg;
        asm_next  = asm_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;

        res            = '0;
        res.pixel_x    = pos_t'(cx_reg);
        res.pixel_y    = pos_t'(cy_reg);
        res.channel    = ch_reg;
        res.exhausted  = done_reg;
        res.last       = 1'b1;

        unique case (slot_req_reg)
            lsbe_pkg::REQ_EMBED:
            begin
                if (!done_reg)
                begin
                    res.is_write  = 1'b1;
                    res.bit_value = slot_msg_reg[idx_reg];
                    res.exhausted = adv_done;
                    res.last      = (idx_reg == lsbe_pkg::LAST_BIT) || adv_done;
                    cx_next       = adv_cx;
                    cy_next       = adv_cy;
                    ch_next       = adv_ch;
                    done_next     = adv_done;
                end
            end
            lsbe_pkg::REQ_EXTRACT:
            begin
                if (!done_reg)
                begin
                    cx_next       = adv_cx;
                    cy_next       = adv_cy;
                    ch_next       = adv_ch;
                    done_next     = adv_done;
                    res.pixel_x   = pos_t'(adv_cx);
                    res.pixel_y   = pos_t'(adv_cy);
                    res.channel   = adv_ch;
                    res.exhausted = adv_done;
                    priority if (cnt_reg == lsbe_pkg::LAST_BIT)
                    begin
                        res.byte_valid = 1'b1;
                        res.byte_out   = asm_sum;
                        asm_next       = '0;
                        cnt_next       = '0;
                    end
                    else if (adv_done)
                    begin
                        asm_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        asm_next = asm_sum;
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            lsbe_pkg::REQ_REWIND:
            begin
                cx_next       = '0;
                cy_next       = '0;
                ch_next       = lsbe_pkg::CH_RED;
                asm_next      = '0;
                cnt_next      = '0;
                done_next     = 1'b0;
                res.pixel_x   = '0;
                res.pixel_y   = '0;
                res.channel   = lsbe_pkg::CH_RED;
                res.exhausted = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            ch_reg   <= lsbe_pkg::CH_RED;
            asm_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (fire)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            ch_reg   <= ch_next;
            asm_reg  <= asm_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign embed_fire  = fire && (slot_req_reg == lsbe_pkg::REQ_EMBED);
    assign rewind_fire = fire && (slot_req_reg == lsbe_pkg::REQ_REWIND);
    assign idx_last    = idx_reg == lsbe_pkg::LAST_BIT;
    assign state_clear = !done_reg && (cnt_reg == '0) && (cx_reg == '0) && (cy_reg == '0);

    `LSBE_ASSERT_HOLDS(a_ch_legal, ch_reg != 2'd3, "channel index out of range")
    `LSBE_ASSERT_IMPL(a_embed_ends, embed_fire && idx_last, res.last, "embed ran past eighth bit")
    `LSBE_ASSERT_NEXT(a_done_sticky, done_reg && !rewind_fire, done_reg, "exhausted flag dropped")
    `LSBE_ASSERT_NEXT(a_rewind_clears, rewind_fire, state_clear, "rewind left state")

endmodule

// ----- rtl/lsbe_out_reg.sv -----
// ----------------------------------------------------------------------------
// LSB embed/extract output register
// Holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module lsbe_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lsbe_pkg::result_t data,
    output logic              space,
    lsbe_res_if.source        res
);

    logic              valid_reg, valid_next;
    lsbe_pkg::result_t data_reg;

    assign space = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign res.valid      = valid_reg;
    assign res.is_write   = data_reg.is_write;
    assign res.pixel_x    = data_reg.pixel_x;
    assign res.pixel_y    = data_reg.pixel_y;
    assign res.channel    = data_reg.channel;
    assign res.bit_value  = data_reg.bit_value;
    assign res.byte_valid = data_reg.byte_valid;
    assign res.byte_out   = data_reg.byte_out;
    assign res.exhausted  = data_reg.exhausted;
    assign res.last       = data_reg.last;

endmodule

// ----- rtl/lsb_pixel_bit_embed_extract.sv -----
// ----------------------------------------------------------------------------
// LSB pixel bit embed/extract
// Raster LSB cursor over an RGB image: embeds message bytes as channel
// writes and assembles extracted bytes from channel samples.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  req     | in  | req_type, message_byte, channel_sample
//  res     | out | is_write, pixel_x, pixel_y, channel, bit_value,
//          |     | byte_valid, byte_out, exhausted, last
//  apb     | in  | image_width @0x0, image_height @0x4
//
//  Extract and rewind: one result beat per request, back to back.
//  Embed: one write beat per cycle while res accepts, eight beats per byte,
//  set by the single cursor advance per cycle; fewer when the image runs out.
//  Unused request code: accepted, no result.
//  A stalled res holds its beat and freezes the slot; req is taken only
//  when the slot is empty or its last beat leaves.
//  Reset clears cursor, partial byte and exhausted flag; size 640 x 480.
// ----------------------------------------------------------------------------
module lsb_pixel_bit_embed_extract #(
    parameter int MAX_DIM = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lsbe_req_if.sink                     req,
    lsbe_res_if.source                   res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsbe_pkg::APB_AW-1:0]  paddr,
    input  logic [lsbe_pkg::APB_DW-1:0]  pwdata,
    output logic [lsbe_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int CMPW = (CW + 1 > lsbe_pkg::CFG_W) ? CW + 1 : lsbe_pkg::CFG_W;

    logic [CMPW-1:0]   dim_w;
    logic [CMPW-1:0]   dim_h;
    logic              out_space;
    logic              out_load;
    lsbe_pkg::result_t out_data;

    lsbe_apb_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim_w   (dim_w),
        .dim_h   (dim_h)
    );

    lsbe_engine #(
        .MAX_DIM (MAX_DIM)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .dim_w     (dim_w),
        .dim_h     (dim_h),
        .out_space (out_space),
        .out_load  (out_load),
        .out_data  (out_data)
    );

    lsbe_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .data  (out_data),
        .space (out_space),
        .res   (res)
    );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// LSB embed/extract testbench
// Drives embed, extract, rewind and unused request beats across several
// image sizes over APB, predicts every result beat with a cursor model in
// a scoreboard class and checks each accepted result beat field by field.
// Both channels idle at random; one long result hold-off fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_DIM        = 4096;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASES         = 12;
    localparam int PHASE_BEATS    = 28;

    class cursor_scoreboard;
        logic [lsbe_pkg::CFG_W-1:0] img_w;
        logic [lsbe_pkg::CFG_W-1:0] img_h;
        logic [lsbe_pkg::POS_W-1:0] cur_x;
        logic [lsbe_pkg::POS_W-1:0] cur_y;
        logic [1:0]                 cur_ch;
        logic [7:0]                 acc_byte;
        logic [3:0]                 acc_bits;
        logic                       done;
        lsbe_pkg::result_t          expected_beats[$];
        int                         errors;

        function new();
            img_w    = lsbe_pkg::WIDTH_RESET;
            img_h    = lsbe_pkg::HEIGHT_RESET;
            errors   = 0;
            clear_cursor();
        endfunction

        function void clear_cursor();
            cur_x    = '0;
            cur_y    = '0;
            cur_ch   = lsbe_pkg::CH_RED;
            acc_byte = '0;
            acc_bits = '0;
            done     = 1'b0;
        endfunction

        function void write_reg(lsbe_pkg::reg_index_t idx, logic [lsbe_pkg::APB_DW-1:0] val);
            if (idx == lsbe_pkg::REG_IMAGE_WIDTH)
                img_w = val[lsbe_pkg::CFG_W-1:0];
            else
                img_h = val[lsbe_pkg::CFG_W-1:0];
        endfunction

        function int dim_used(logic [lsbe_pkg::CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (int'(v) > MAX_DIM)
                return MAX_DIM;
            return int'(v);
        endfunction

        function void step_cursor();
            if (cur_ch < lsbe_pkg::CH_BLUE)
            begin
                cur_ch++;
            end
            else
            begin
                cur_ch = lsbe_pkg::CH_RED;
                if (int'(cur_x) + 1 < dim_used(img_w))
                begin
                    cur_x++;
                end
                else if (int'(cur_y) + 1 < dim_used(img_h))
                begin
                    cur_x = '0;
                    cur_y++;
                end
                else
                begin
                    done = 1'b1;
                end
            end
        endfunction

        function void push_beat(logic wr, logic [lsbe_pkg::POS_W-1:0] x,
                                logic [lsbe_pkg::POS_W-1:0] y,
                                logic [1:0] ch, logic wbit, logic bv,
                                logic [7:0] data, logic fin);
            lsbe_pkg::result_t r;
            r.is_write   = wr;
            r.pixel_x    = x;
            r.pixel_y    = y;
            r.channel    = ch;
            r.bit_value  = wbit;
            r.byte_valid = bv;
            r.byte_out   = data;
            r.exhausted  = done;
            r.last       = fin;
            expected_beats.push_back(r);
        endfunction

        function void note_request(lsbe_pkg::req_type_t kind, logic [7:0] msg,
                                   logic [7:0] smp);
            logic [lsbe_pkg::POS_W-1:0] x;
            logic [lsbe_pkg::POS_W-1:0] y;
            logic [1:0]                 ch;
            logic                       bv;
            logic [7:0]                 data;
            case (kind)
                lsbe_pkg::REQ_EMBED:
                begin
                    if (done)
                    begin
                        push_beat(1'b0, cur_x, cur_y, cur_ch, 1'b0, 1'b0, 8'h00, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            x  = cur_x;
                            y  = cur_y;
                            ch = cur_ch;
                            step_cursor();
                            push_beat(1'b1, x, y, ch, msg[i], 1'b0, 8'h00,
                                      (i == int'(lsbe_pkg::LAST_BIT)) || done);
                            if (done)
                                break;
                        end
                    end
                end
                lsbe_pkg::REQ_EXTRACT:
                begin
                    bv   = 1'b0;
                    data = 8'h00;
                    if (!done)
                    begin
                        acc_byte = acc_byte | (8'(smp[0]) << acc_bits[2:0]);
                        acc_bits++;
                        step_cursor();
                        if (acc_bits >= 4'd8)
                        begin
                            bv       = 1'b1;
                            data     = acc_byte;
                            acc_byte = '0;
                            acc_bits = '0;
                        end
                        else if (done)
                        begin
                            acc_byte = '0;
                            acc_bits = '0;
                        end
                    end
                    push_beat(1'b0, cur_x, cur_y, cur_ch, 1'b0, bv, data, 1'b1);
                end
                lsbe_pkg::REQ_REWIND:
                begin
                    clear_cursor();
                    push_beat(1'b0, '0, '0, lsbe_pkg::CH_RED, 1'b0, 1'b0, 8'h00, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(lsbe_pkg::result_t got);
            lsbe_pkg::result_t exp;
            if (expected_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %p", got);
                return;
            end
            exp = expected_beats.pop_front();
            if (got.is_write !== exp.is_write || got.pixel_x !== exp.pixel_x ||
                got.pixel_y !== exp.pixel_y || got.channel !== exp.channel ||
                got.bit_value !== exp.bit_value || got.byte_valid !== exp.byte_valid ||
                got.byte_out !== exp.byte_out || got.exhausted !== exp.exhausted ||
                got.last !== exp.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("exp wr=%0d x=%0d y=%0d ch=%0d b=%0d bv=%0d d=%02h ex=%0d l=%0d",
                             exp.is_write, exp.pixel_x, exp.pixel_y, exp.channel,
                             exp.bit_value, exp.byte_valid, exp.byte_out,
                             exp.exhausted, exp.last);
                    $display("got wr=%0d x=%0d y=%0d ch=%0d b=%0d bv=%0d d=%02h ex=%0d l=%0d",
                             got.is_write, got.pixel_x, got.pixel_y, got.channel,
                             got.bit_value, got.byte_valid, got.byte_out,
                             got.exhausted, got.last);
                end
            end
        endfunction

        function int outstanding();
            return expected_beats.size();
        endfunction
    endclass

    logic                        clk   = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [lsbe_pkg::APB_AW-1:0] paddr;
    logic [lsbe_pkg::APB_DW-1:0] pwdata;
    logic [lsbe_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    lsbe_req_if req_ch();
    lsbe_res_if res_ch();

    cursor_scoreboard sb;
    int idle_cycles = 0;
    int hold_cycles = 0;
    int rx_stall    = 0;
    bit tx_no_idle  = 1'b0;
    bit rx_no_idle  = 1'b0;

    lsb_pixel_bit_embed_extract #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .res     (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // beat monitor: inputs are noted before results so same-edge order holds
    always @(posedge clk)
    begin
        lsbe_pkg::result_t got;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(lsbe_pkg::req_type_t'(req_ch.req_type),
                                req_ch.message_byte, req_ch.channel_sample);
            if (res_ch.valid && res_ch.ready)
            begin
                got.is_write   = res_ch.is_write;
                got.pixel_x    = res_ch.pixel_x;
                got.pixel_y    = res_ch.pixel_y;
                got.channel    = res_ch.channel;
                got.bit_value  = res_ch.bit_value;
                got.byte_valid = res_ch.byte_valid;
                got.byte_out   = res_ch.byte_out;
                got.exhausted  = res_ch.exhausted;
                got.last       = res_ch.last;
                sb.check_result(got);
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("lsb_pixel_bit_embed_extract verification failed");
        $finish;
    end

    // result side: random stalls plus the long hold-off
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (rx_stall > 0)
            begin
                res_ch.ready <= 1'b0;
                rx_stall--;
            end
            else if (rx_no_idle)
            begin
                res_ch.ready <= 1'b1;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                begin
                    res_ch.ready <= 1'b1;
                end
                else
                begin
                    res_ch.ready <= 1'b0;
                    rx_stall = gap - 1;
                end
            end
        end
    end

    task automatic send_beat(lsbe_pkg::req_type_t kind, logic [7:0] msg, logic [7:0] smp);
        int gap;
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.message_byte   <= msg;
        req_ch.channel_sample <= smp;
        do @(posedge clk); while (!req_ch.ready);
        gap = tx_no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid          <= 1'b0;
            req_ch.message_byte   <= 8'($urandom);
            req_ch.channel_sample <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(lsbe_pkg::reg_index_t idx, logic [lsbe_pkg::APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lsbe_pkg::APB_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(logic [lsbe_pkg::APB_DW-1:0] w, logic [lsbe_pkg::APB_DW-1:0] h);
        wait_drained();
        apb_write(lsbe_pkg::REG_IMAGE_WIDTH, w);
        apb_write(lsbe_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    // one well-formed burst or a bit of noise; returns beats that do work
    task automatic run_burst(output int n);
        int r;
        int len;
        n = 0;
        r = $urandom_range(0, 99);
        if (sb.done && $urandom_range(0, 2) == 0)
        begin
            send_beat(lsbe_pkg::REQ_REWIND, 8'($urandom), 8'($urandom));
            n = 1;
        end
        else if (r < 40)
        begin
            len = $urandom_range(1, 3);
            repeat (len) send_beat(lsbe_pkg::REQ_EMBED, 8'($urandom), 8'($urandom));
            n = len;
        end
        else if (r < 80)
        begin
            len = ($urandom_range(0, 9) < 7) ? 8 : $urandom_range(1, 12);
            repeat (len) send_beat(lsbe_pkg::REQ_EXTRACT, 8'($urandom), 8'($urandom));
            n = len;
        end
        else if (r < 88)
        begin
            send_beat(lsbe_pkg::REQ_REWIND, 8'($urandom), 8'($urandom));
            n = 1;
        end
        else if (r < 95)
        begin
            send_beat(lsbe_pkg::REQ_NOP, 8'($urandom), 8'($urandom));
        end
        else
        begin
            len = $urandom_range(0, 3);
            send_beat(lsbe_pkg::req_type_t'(len), 8'($urandom), 8'($urandom));
            n = (len == int'(lsbe_pkg::REQ_NOP)) ? 0 : 1;
        end
    endtask

    initial
    begin
        int phase_beats;
        int n;
        logic [7:0] samples[8];
        sb = new();
        req_ch.valid          = 1'b0;
        req_ch.req_type       = lsbe_pkg::REQ_NOP;
        req_ch.message_byte   = 8'h00;
        req_ch.channel_sample = 8'h00;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        samples = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'hFE, 8'h80, 8'h7F};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset size, then shrink under the cursor to 1 x 1
        send_beat(lsbe_pkg::REQ_EMBED, 8'h00, 8'hFF);
        send_beat(lsbe_pkg::REQ_EMBED, 8'hFF, 8'h00);
        send_beat(lsbe_pkg::REQ_EMBED, 8'hA5, 8'h5A);
        foreach (samples[i])
            send_beat(lsbe_pkg::REQ_EXTRACT, ~samples[i], samples[i]);
        send_beat(lsbe_pkg::REQ_NOP, 8'hFF, 8'hFF);
        set_size(32'd0, 32'd0);
        send_beat(lsbe_pkg::REQ_EMBED, 8'h5A, 8'h00);
        send_beat(lsbe_pkg::REQ_EMBED, 8'h3C, 8'h00);
        send_beat(lsbe_pkg::REQ_EXTRACT, 8'h00, 8'hFF);
        send_beat(lsbe_pkg::REQ_REWIND, 8'hFF, 8'hFF);
        send_beat(lsbe_pkg::REQ_EXTRACT, 8'h00, 8'h01);
        send_beat(lsbe_pkg::REQ_EXTRACT, 8'h00, 8'h00);
        send_beat(lsbe_pkg::REQ_EXTRACT, 8'h00, 8'h01);
        send_beat(lsbe_pkg::REQ_REWIND, 8'h00, 8'h00);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_size(32'd8191, 32'd8191);
                1: set_size(32'd4096, 32'd1);
                2: set_size(32'd8, 32'd1);
                3: set_size(32'd1, 32'd4096);
                default:
                begin
                    n = $urandom_range(0, 9);
                    if (n < 6)
                        set_size($urandom_range(1, 6), $urandom_range(1, 6));
                    else if (n < 8)
                        set_size(32'd2, 32'd4);
                    else
                        set_size(32'($urandom), 32'($urandom));
                end
            endcase
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            if (ph == 5)
            begin
                tx_no_idle  = 1'b1;
                hold_cycles = 150;
            end
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
            begin
                run_burst(n);
                phase_beats += n;
                if (ph == 7 && phase_beats >= PHASE_BEATS / 2 &&
                    phase_beats - n < PHASE_BEATS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("lsb_pixel_bit_embed_extract verification clean");
        else
            $display("lsb_pixel_bit_embed_extract verification failed");
        $finish;
    end

endmodule
